@@ hdl/fnws_pkg.sv @@
// Shared types, constants and state codes for the filtered-noise wind synth.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package fnws_pkg;

    // Digit-serial multiplier geometry
    localparam int DIG_W      = 4;
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 32;
    localparam int MUL_DIGITS = MUL_B_W / DIG_W;
    localparam int DCNT_W     = $clog2(MUL_DIGITS);
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    // Field and state widths
    localparam int TGT_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int NOISE_W  = 24;
    localparam int LVL_W    = 32;
    localparam int SEED_W   = 32;

    typedef logic [DCNT_W-1:0] t_dig;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIND_TARGET   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUMBLE_TARGET = 1'd1;

    localparam logic [SEED_W-1:0] SEED_RESET = 32'h9e37_79b9;
    localparam logic [TGT_W-1:0]  UNITY_Q15  = 16'd32768;

    // Coefficients (multiplier side) and the index of their top nonzero digit
    localparam logic [MUL_B_W-1:0] K_SMOOTH    = 32'd2576980;  // 0.0006, Q0.32
    localparam logic [MUL_B_W-1:0] K_MID       = 32'd3932;     // 0.06,   Q0.16
    localparam logic [MUL_B_W-1:0] K_FAST      = 32'd26214;    // 0.40
    localparam logic [MUL_B_W-1:0] K_SLOW      = 32'd786;      // 0.012
    localparam logic [MUL_B_W-1:0] K_MIX_A     = 32'd42598;    // 0.65
    localparam logic [MUL_B_W-1:0] K_MIX_B     = 32'd22938;    // 0.35
    localparam logic [MUL_B_W-1:0] WIND_GAIN   = 32'd27000;
    localparam logic [MUL_B_W-1:0] RUMBLE_GAIN = 32'd120000;   // 4 * 30000

    localparam t_dig LAST_SMOOTH = 3'd5;
    localparam t_dig LAST_MID    = 3'd2;
    localparam t_dig LAST_FAST   = 3'd3;
    localparam t_dig LAST_SLOW   = 3'd2;
    localparam t_dig LAST_MIX    = 3'd3;
    localparam t_dig LAST_FULL   = t_dig'(MUL_DIGITS - 1);
    localparam t_dig LAST_WGAIN  = 3'd3;
    localparam t_dig LAST_RGAIN  = 3'd4;

    // Multiplier request / response
    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0]        b;
        t_dig                      last;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] product;
    } t_mul_rsp;

    // Sequencer status toward the top level
    typedef struct packed {
        logic                       idle;
        logic                       res_valid;
        logic signed [SAMPLE_W-1:0] sample;
    } t_seq_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WSM,
        ST_RSM,
        ST_MID,
        ST_FAST,
        ST_SLOW,
        ST_MIXA,
        ST_MIXB,
        ST_SQ,
        ST_WIND,
        ST_RUMB,
        ST_WGAIN,
        ST_RGAIN,
        ST_HOLD
    } t_state;

endpackage

@@ hdl/fnws_dmul.sv @@
// Digit-serial signed x unsigned multiplier, DIG_W multiplier bits per cycle.
// Depends on fnws_pkg.
`timescale 1ns / 1ps

module fnws_dmul import fnws_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam int HI_W  = MUL_A_W + DIG_W;
    localparam int SUM_W = HI_W + 1;
    localparam int SH_W  = $clog2(PROD_W);

    logic signed [MUL_A_W-1:0] r_a;
    logic [MUL_B_W-1:0]        r_b;
    logic signed [HI_W-1:0]    r_hi;
    logic [MUL_B_W-1:0]        r_lo;
    t_dig                      r_cnt;
    t_dig                      r_last;
    logic                      r_busy;
    logic                      r_done;

    logic signed [SUM_W-1:0]  w_pp;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [PROD_W-1:0] w_full;
    logic [SH_W-1:0]          w_shamt;

    // partial product of one digit, added to the running upper half
    assign w_pp  = r_a * $signed({1'b0, r_b[DIG_W-1:0]});
    assign w_sum = {r_hi[HI_W-1], r_hi} + w_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a    <= i_req.a;
            r_b    <= i_req.b;
            r_hi   <= '0;
            r_lo   <= '0;
            r_cnt  <= i_req.last;
            r_last <= i_req.last;
        end else if (r_busy) begin
            r_hi  <= {{(DIG_W-1){w_sum[SUM_W-1]}}, w_sum[SUM_W-1:DIG_W]};
            r_lo  <= {w_sum[DIG_W-1:0], r_lo[MUL_B_W-1:DIG_W]};
            r_b   <= r_b >> DIG_W;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // fewer digits leave the low product bits higher up in r_lo
    assign w_full  = {r_hi[MUL_A_W-1:0], r_lo};
    assign w_shamt = SH_W'((MUL_DIGITS - 1 - int'(r_last)) * DIG_W);

    assign o_rsp.done    = r_done;
    assign o_rsp.product = w_full >>> w_shamt;

endmodule

@@ hdl/fnws_noise.sv @@
// xorshift32 noise source (13, 17, 5); steps once per sample.
// Depends on fnws_pkg.
`timescale 1ns / 1ps

module fnws_noise import fnws_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    output logic signed [NOISE_W-1:0] o_white
);

    logic [SEED_W-1:0] r_seed;
    logic [SEED_W-1:0] w_x1;
    logic [SEED_W-1:0] w_x2;
    logic [SEED_W-1:0] n_seed;

    assign w_x1   = r_seed ^ (r_seed << 13);
    assign w_x2   = w_x1 ^ (w_x1 >> 17);
    assign n_seed = w_x2 ^ (w_x2 << 5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_step) begin
            r_seed <= n_seed;
        end
    end

    // low 16 bits minus 32768 is the same word with its top bit flipped;
    // sign-extended into Q1.22
    assign o_white = {{2{~r_seed[15]}}, r_seed[14:0], 7'b0};

endmodule

@@ hdl/fnws_seq.sv @@
// Per-sample sequencer: smoothers, three one-pole filters, mix, gains, saturation.
// Depends on fnws_pkg; drives fnws_dmul and steps fnws_noise.
`timescale 1ns / 1ps

module fnws_seq import fnws_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic                      i_take,
    input  logic [TGT_W-1:0]          i_wind_tgt,
    input  logic [TGT_W-1:0]          i_rumb_tgt,
    input  logic signed [NOISE_W-1:0] i_white,
    output logic                      o_step,
    output t_mul_req                  o_mul_req,
    input  t_mul_rsp                  i_mul_rsp,
    output t_seq_stat                 o_stat
);

    localparam int ACC_W  = 41;
    localparam int MIX_W  = 25;
    localparam int SQ_W   = 31;
    localparam int DIFF_W = NOISE_W + 1;
    localparam int OUT_SH = 22;
    localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((64'sd1 <<< OUT_SH) - 1);
    localparam logic signed [PROD_W-1:0] SAT_MAX    = 64'sd32767;
    localparam logic signed [PROD_W-1:0] SAT_MIN    = -64'sd32768;

    // round to nearest, ties toward +inf
    function automatic logic signed [PROD_W-1:0] rnd(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              s
    );
        return (v + $signed(PROD_W'(1) << (s - 1))) >>> s;
    endfunction

    t_state                     r_state, n_state;
    logic                       r_wait, n_wait;
    logic signed [LVL_W-1:0]    r_wind_lvl, n_wind_lvl;
    logic signed [LVL_W-1:0]    r_rumb_lvl, n_rumb_lvl;
    logic signed [NOISE_W-1:0]  r_mid, n_mid;
    logic signed [NOISE_W-1:0]  r_fast, n_fast;
    logic signed [NOISE_W-1:0]  r_slow, n_slow;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic signed [MIX_W-1:0]    r_mix, n_mix;
    logic [SQ_W-1:0]            r_sq, n_sq;
    logic signed [MIX_W-1:0]    r_wind, n_wind;
    logic signed [MIX_W-1:0]    r_rumb, n_rumb;
    logic signed [SAMPLE_W-1:0] r_sample, n_sample;

    t_mul_req                   w_req;
    logic                       w_adv;
    logic signed [PROD_W-1:0]   w_p;
    logic signed [PROD_W-1:0]   w_acc_ext;
    logic signed [PROD_W-1:0]   w_total;
    logic signed [PROD_W-1:0]   w_trunc;
    logic [TGT_W-1:0]           w_tw, w_tr;
    logic signed [DIFF_W-1:0]   w_d_mid, w_d_fast, w_d_slow;

    assign w_p       = i_mul_rsp.product;
    assign w_adv     = r_wait && i_mul_rsp.done;
    assign w_acc_ext = {{(PROD_W-ACC_W){r_acc[ACC_W-1]}}, r_acc};

    // targets above unity count as unity
    assign w_tw = (i_wind_tgt > UNITY_Q15) ? UNITY_Q15 : i_wind_tgt;
    assign w_tr = (i_rumb_tgt > UNITY_Q15) ? UNITY_Q15 : i_rumb_tgt;

    assign w_d_mid  = {i_white[NOISE_W-1], i_white} - {r_mid[NOISE_W-1], r_mid};
    assign w_d_fast = {i_white[NOISE_W-1], i_white} - {r_fast[NOISE_W-1], r_fast};
    assign w_d_slow = {i_white[NOISE_W-1], i_white} - {r_slow[NOISE_W-1], r_slow};

    // output: truncate toward zero, then saturate
    assign w_total = w_acc_ext + w_p;
    assign w_trunc = w_total[PROD_W-1] ? ((w_total + TRUNC_BIAS) >>> OUT_SH)
                                       : (w_total >>> OUT_SH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wait     <= 1'b0;
            r_wind_lvl <= '0;
            r_rumb_lvl <= '0;
            r_mid      <= '0;
            r_fast     <= '0;
            r_slow     <= '0;
        end else begin
            r_state    <= n_state;
            r_wait     <= n_wait;
            r_wind_lvl <= n_wind_lvl;
            r_rumb_lvl <= n_rumb_lvl;
            r_mid      <= n_mid;
            r_fast     <= n_fast;
            r_slow     <= n_slow;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mix    <= n_mix;
        r_sq     <= n_sq;
        r_wind   <= n_wind;
        r_rumb   <= n_rumb;
        r_sample <= n_sample;
    end

    always_comb begin
        n_state    = r_state;
        n_wind_lvl = r_wind_lvl;
        n_rumb_lvl = r_rumb_lvl;
        n_mid      = r_mid;
        n_fast     = r_fast;
        n_slow     = r_slow;
        n_acc      = r_acc;
        n_mix      = r_mix;
        n_sq       = r_sq;
        n_wind     = r_wind;
        n_rumb     = r_rumb;
        n_sample   = r_sample;
        w_req      = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_go) n_state = ST_WSM;
            end
            ST_WSM: begin
                w_req.a    = $signed({1'b0, w_tw, 15'b0}) - r_wind_lvl;
                w_req.b    = K_SMOOTH;
                w_req.last = LAST_SMOOTH;
                if (w_adv) begin
                    n_wind_lvl = r_wind_lvl + LVL_W'(rnd(w_p, 32));
                    n_state    = ST_RSM;
                end
            end
            ST_RSM: begin
                w_req.a    = $signed({1'b0, w_tr, 15'b0}) - r_rumb_lvl;
                w_req.b    = K_SMOOTH;
                w_req.last = LAST_SMOOTH;
                if (w_adv) begin
                    n_rumb_lvl = r_rumb_lvl + LVL_W'(rnd(w_p, 32));
                    n_state    = ST_MID;
                end
            end
            ST_MID: begin
                w_req.a    = {{(MUL_A_W-DIFF_W){w_d_mid[DIFF_W-1]}}, w_d_mid};
                w_req.b    = K_MID;
                w_req.last = LAST_MID;
                if (w_adv) begin
                    n_mid   = r_mid + NOISE_W'(rnd(w_p, 16));
                    n_state = ST_FAST;
                end
            end
            ST_FAST: begin
                w_req.a    = {{(MUL_A_W-DIFF_W){w_d_fast[DIFF_W-1]}}, w_d_fast};
                w_req.b    = K_FAST;
                w_req.last = LAST_FAST;
                if (w_adv) begin
                    n_fast  = r_fast + NOISE_W'(rnd(w_p, 16));
                    n_state = ST_SLOW;
                end
            end
            ST_SLOW: begin
                w_req.a    = {{(MUL_A_W-DIFF_W){w_d_slow[DIFF_W-1]}}, w_d_slow};
                w_req.b    = K_SLOW;
                w_req.last = LAST_SLOW;
                if (w_adv) begin
                    n_slow  = r_slow + NOISE_W'(rnd(w_p, 16));
                    n_state = ST_MIXA;
                end
            end
            ST_MIXA: begin
                w_req.a    = {{(MUL_A_W-NOISE_W){r_mid[NOISE_W-1]}}, r_mid};
                w_req.b    = K_MIX_A;
                w_req.last = LAST_MIX;
                if (w_adv) begin
                    n_acc   = ACC_W'(w_p);
                    n_state = ST_MIXB;
                end
            end
            ST_MIXB: begin
                w_req.a    = {{(MUL_A_W-NOISE_W){r_fast[NOISE_W-1]}}, r_fast};
                w_req.b    = K_MIX_B;
                w_req.last = LAST_MIX;
                if (w_adv) begin
                    n_mix   = MIX_W'(rnd(w_acc_ext + w_p, 16));
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                w_req.a    = r_wind_lvl;
                w_req.b    = r_wind_lvl;
                w_req.last = LAST_FULL;
                if (w_adv) begin
                    n_sq    = SQ_W'(rnd(w_p, 30));
                    n_state = ST_WIND;
                end
            end
            ST_WIND: begin
                w_req.a    = {{(MUL_A_W-MIX_W){r_mix[MIX_W-1]}}, r_mix};
                w_req.b    = {1'b0, r_sq};
                w_req.last = LAST_FULL;
                if (w_adv) begin
                    n_wind  = MIX_W'(rnd(w_p, 30));
                    n_state = ST_RUMB;
                end
            end
            ST_RUMB: begin
                w_req.a    = {{(MUL_A_W-NOISE_W){r_slow[NOISE_W-1]}}, r_slow};
                w_req.b    = r_rumb_lvl;
                w_req.last = LAST_FULL;
                if (w_adv) begin
                    n_rumb  = MIX_W'(rnd(w_p, 30));
                    n_state = ST_WGAIN;
                end
            end
            ST_WGAIN: begin
                w_req.a    = {{(MUL_A_W-MIX_W){r_wind[MIX_W-1]}}, r_wind};
                w_req.b    = WIND_GAIN;
                w_req.last = LAST_WGAIN;
                if (w_adv) begin
                    n_acc   = ACC_W'(w_p);
                    n_state = ST_RGAIN;
                end
            end
            ST_RGAIN: begin
                w_req.a    = {{(MUL_A_W-MIX_W){r_rumb[MIX_W-1]}}, r_rumb};
                w_req.b    = RUMBLE_GAIN;
                w_req.last = LAST_RGAIN;
                if (w_adv) begin
                    if (w_trunc > SAT_MAX) begin
                        n_sample = SAMPLE_W'(SAT_MAX);
                    end else if (w_trunc < SAT_MIN) begin
                        n_sample = SAMPLE_W'(SAT_MIN);
                    end else begin
                        n_sample = SAMPLE_W'(w_trunc);
                    end
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (i_take) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase

        // launch the multiply once on entry to each arithmetic state
        w_req.start = !r_wait && (r_state != ST_IDLE) && (r_state != ST_HOLD);
        n_wait = r_wait;
        if (w_req.start) begin
            n_wait = 1'b1;
        end else if (w_adv) begin
            n_wait = 1'b0;
        end
    end

    assign o_step           = i_go && (r_state == ST_IDLE);
    assign o_mul_req        = w_req;
    assign o_stat.idle      = (r_state == ST_IDLE);
    assign o_stat.res_valid = (r_state == ST_HOLD);
    assign o_stat.sample    = r_sample;

endmodule

@@ hdl/filtered_noise_wind_synth.sv @@
// Top level of the filtered-noise wind synth: ports, config registers, output register.
// Depends on fnws_pkg, fnws_dmul, fnws_noise, fnws_seq.
`timescale 1ns / 1ps

// Wind and rumble synthesizer, one signed 16-bit sample per request word.
// Each accepted word steps a xorshift32 noise source, moves the wind and
// rumble level smoothers toward their targets (Q1.15, values above 1.0 are
// clamped), runs three one-pole lowpass filters over the noise, and forms
//   wind + rumble = (0.65*mid + 0.35*fast) * wind_lvl^2 * 27000
//                 + slow * 4 * rumble_lvl * 30000,
// truncated toward zero and saturated to 16 bits. end_of_block is carried
// through to last_of_block of the same sample.
// Timing: all twelve products go through one shared multiplier that takes
// 4 multiplier bits per cycle, one product after another.
// One word is worked on at a time; o_in_stall is high from acceptance until
// the sample has moved into the output register, so a new word is taken
// while a finished sample still waits on a stalled output.
// Config writes (wind_target = index 0, rumble_target = index 1) take effect
// for the next accepted word and are only to be made while the block is idle.

module filtered_noise_wind_synth import fnws_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // config
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [TGT_W-1:0]           i_cfg_data,
    // request words
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_end_of_block,
    // sample words
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_last_of_block
);

    logic [TGT_W-1:0]           r_wind_tgt;
    logic [TGT_W-1:0]           r_rumb_tgt;
    logic                       r_eob;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_last;

    logic                       w_go;
    logic                       w_take;
    logic                       w_step;
    logic signed [NOISE_W-1:0]  w_white;
    t_mul_req                   w_mul_req;
    t_mul_rsp                   w_mul_rsp;
    t_seq_stat                  w_stat;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wind_tgt <= '0;
            r_rumb_tgt <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIND_TARGET:   r_wind_tgt <= i_cfg_data;
                CFG_RUMBLE_TARGET: r_rumb_tgt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input side: one word in flight
    assign o_in_stall = !w_stat.idle;
    assign w_go       = i_in_valid && w_stat.idle;

    always_ff @(posedge i_clk) begin
        if (w_go) r_eob <= i_end_of_block;
    end

    // output register; the finished sample moves in once it is free or drained
    assign w_take = w_stat.res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_sample <= w_stat.sample;
            r_out_last   <= r_eob;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample        = r_out_sample;
    assign o_last_of_block = r_out_last;

    fnws_noise u_noise (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .o_white (w_white)
    );

    fnws_dmul u_dmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    fnws_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (w_go),
        .i_take     (w_take),
        .i_wind_tgt (r_wind_tgt),
        .i_rumb_tgt (r_rumb_tgt),
        .i_white    (w_white),
        .o_step     (w_step),
        .o_mul_req  (w_mul_req),
        .i_mul_rsp  (w_mul_rsp),
        .o_stat     (w_stat)
    );

endmodule

@@ sim/tb_filtered_noise_wind_synth.sv @@
// Self-checking testbench for filtered_noise_wind_synth: request words in, checked samples out.
// Depends on fnws_pkg and the block's RTL; predicts each sample in a small scoreboard class.
`timescale 1ns / 1ps

// Test plan
//   - Reset once. A short directed run then covers:
//       * both targets at zero;
//       * each target at 1.0;
//       * a target above 1.0, which the block clamps;
//       * the largest register value;
//       * target changes between words of an unfinished buffer.
//   - Then eight random phases of 200 request words each. New targets are
//     written before each phase, with extremes mixed in. The phases rotate
//     through these idling modes:
//       * no idling;
//       * sender idle 70% of cycles;
//       * receiver stalling 70% of cycles;
//       * both sides at 21%.
//   - During the first phase the receiver also holds off for a long stretch.
//     The block then fills up and must stall its input.
// Every accepted request word gets its expected sample from a bit-exact
// predictor: xorshift32 noise, three one-pole lowpass filters, two level
// smoothers, a wind/rumble mix, truncation and saturation. Samples are
// checked in order.
// Config writes happen only after the block has drained, since a target
// is read at every step.

module tb_filtered_noise_wind_synth;
    import fnws_pkg::*;

    localparam int  CLK_HALF        = 5;
    localparam int  RESET_CYCLES    = 5;
    localparam int  PHASES          = 8;
    localparam int  WORDS_PER_PHASE = 200;
    localparam int  HOLD_CYCLES     = 400;
    localparam int  SETTLE_CYCLES   = 100;
    localparam int  CYCLE_LIMIT     = 2_000_000;
    localparam int  MAX_PRINTS      = 40;

    // fixed-point coefficients, kept signed so products stay signed
    localparam longint K_SMOOTH_Q32 = 2576980;  // 0.0006
    localparam longint K_MID_Q16    = 3932;     // 0.06
    localparam longint K_FAST_Q16   = 26214;    // 0.40
    localparam longint K_SLOW_Q16   = 786;      // 0.012
    localparam longint K_MIXA_Q16   = 42598;    // 0.65
    localparam longint K_MIXB_Q16   = 22938;    // 0.35
    localparam longint WIND_SCALE   = 27000;
    localparam longint RUMBLE_SCALE = 120000;   // 4 * 30000

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       last;
    } sample_word_t;

    // Predicts the sample of every accepted request word and checks the
    // samples the block delivers, oldest first.
    class wind_sample_book;
        sample_word_t      pending_samples[$];
        int                errors;
        logic [TGT_W-1:0]  wind_tgt;
        logic [TGT_W-1:0]  rumble_tgt;
        logic [SEED_W-1:0] seed;
        int                mid_lp;      // Q1.22
        int                fast_lp;
        int                slow_lp;
        int                wind_lvl;    // Q1.30
        int                rumble_lvl;

        function new();
            errors     = 0;
            wind_tgt   = '0;
            rumble_tgt = '0;
            seed       = SEED_RESET;
            mid_lp     = 0;
            fast_lp    = 0;
            slow_lp    = 0;
            wind_lvl   = 0;
            rumble_lvl = 0;
        endfunction

        // round to nearest, ties toward +inf
        function longint rnd_shift(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function int pole_step(int y, int x, longint k);
            return int'(longint'(y) + rnd_shift((longint'(x) - longint'(y)) * k, 16));
        endfunction

        function int level_step(int y, logic [TGT_W-1:0] tgt);
            logic [TGT_W-1:0] t;
            longint           d;
            t = (tgt > UNITY_Q15) ? UNITY_Q15 : tgt;
            d = longint'(t) * 32768 - longint'(y);
            return int'(longint'(y) + rnd_shift(d * K_SMOOTH_Q32, 32));
        endfunction

        function void set_target(logic [CFG_IDX_W-1:0] idx, logic [TGT_W-1:0] val);
            if (idx == CFG_WIND_TARGET)
                wind_tgt = val;
            else if (idx == CFG_RUMBLE_TARGET)
                rumble_tgt = val;
        endfunction

        // one synth step per accepted request word
        function void take_request(logic eob);
            logic [SEED_W-1:0] r;
            int                white;
            longint            mix, sq, wind, rumble, total, v;
            sample_word_t      w;
            wind_lvl   = level_step(wind_lvl, wind_tgt);
            rumble_lvl = level_step(rumble_lvl, rumble_tgt);

            r = seed;
            r ^= r << 13;
            r ^= r >> 17;
            r ^= r << 5;
            seed  = r;
            white = (int'({16'h0, r[15:0]}) - 32768) * 128;

            mid_lp  = pole_step(mid_lp, white, K_MID_Q16);
            fast_lp = pole_step(fast_lp, white, K_FAST_Q16);
            slow_lp = pole_step(slow_lp, white, K_SLOW_Q16);

            mix    = rnd_shift(longint'(mid_lp) * K_MIXA_Q16
                               + longint'(fast_lp) * K_MIXB_Q16, 16);
            sq     = rnd_shift(longint'(wind_lvl) * longint'(wind_lvl), 30);
            wind   = rnd_shift(mix * sq, 30);
            rumble = rnd_shift(longint'(slow_lp) * longint'(rumble_lvl), 30);

            // truncate toward zero, then saturate
            total = wind * WIND_SCALE + rumble * RUMBLE_SCALE;
            if (total < 0)
                v = -((-total) >>> 22);
            else
                v = total >>> 22;
            if (v < -32768)
                v = -32768;
            if (v > 32767)
                v = 32767;

            w.smp  = SAMPLE_W'(v);
            w.last = eob;
            pending_samples.push_back(w);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("%0t mismatch: %s", $time, msg);
        endtask

        task take_sample(logic signed [SAMPLE_W-1:0] smp, logic last);
            sample_word_t w;
            if (pending_samples.size() == 0) begin
                report($sformatf("sample %0d with no request outstanding", smp));
                return;
            end
            w = pending_samples.pop_front();
            if (smp !== w.smp)
                report($sformatf("sample got %0d want %0d", smp, w.smp));
            if (last !== w.last)
                report($sformatf("last_of_block got %b want %b", last, w.last));
        endtask
    endclass

    logic                       i_clk           = 1'b0;
    logic                       i_rst_n         = 1'b0;
    logic                       cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index       = CFG_WIND_TARGET;
    logic [TGT_W-1:0]           cfg_data        = '0;
    logic                       in_valid        = 1'b0;
    logic                       end_of_block    = 1'b0;
    logic                       out_stall       = 1'b0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic signed [SAMPLE_W-1:0] o_sample;
    logic                       o_last_of_block;

    wind_sample_book book = new();

    int   src_idle_pct   = 0;    // used by the sender only
    int   sink_stall_pct = 0;    // read by the receiver process
    logic hold_arm       = 1'b0;
    logic hold_done      = 1'b0;
    int   hold_left      = 0;
    int   cycles         = 0;

    filtered_noise_wind_synth u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_end_of_block  (end_of_block),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_sample        (o_sample),
        .o_last_of_block (o_last_of_block)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Long receiver hold-off, armed once by the stimulus and counted here.
    always @(posedge i_clk) begin
        if (hold_arm && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: check every sample word taken, then pick the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !out_stall)
                book.take_sample(o_sample, o_last_of_block);
            if (hold_left != 0)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    // Watchdog
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[filtered_noise_wind_synth] ERROR");
        $finish;
    end

    // Offer one request word, after a random gap, and hold it until taken.
    task automatic send_word(input logic eob);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        end_of_block <= eob;
        do
            @(posedge i_clk);
        while (o_in_stall);
        book.take_request(eob);
    endtask

    // Both targets back to back; only called with the block idle.
    task automatic write_targets(input logic [TGT_W-1:0] wind_val,
                                 input logic [TGT_W-1:0] rumble_val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WIND_TARGET;
        cfg_data  <= wind_val;
        @(posedge i_clk);
        book.set_target(CFG_WIND_TARGET, wind_val);
        cfg_index <= CFG_RUMBLE_TARGET;
        cfg_data  <= rumble_val;
        @(posedge i_clk);
        book.set_target(CFG_RUMBLE_TARGET, rumble_val);
        cfg_we    <= 1'b0;
    endtask

    // Stop offering, wait for every outstanding sample, then let the block go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (book.pending_samples.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Targets lean high so the slow smoothers build up real level.
    function automatic logic [TGT_W-1:0] pick_target();
        case ($urandom_range(7))
            0: return '0;
            1: return UNITY_Q15;
            2: return '1;
            3: return TGT_W'($urandom_range(65535));
            default: return TGT_W'($urandom_range(32768, 20000));
        endcase
    endfunction

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // Directed: reset targets give silence
        send_word(1'b0);
        send_word(1'b1);
        settle();

        // Unity wind and a clamped rumble target, buffer left open
        write_targets(UNITY_Q15, '1);
        for (int n = 0; n < 8; n++)
            send_word(n == 5);
        settle();

        // Mid-buffer change: largest register value and just above 1.0
        write_targets('1, UNITY_Q15 + 1'b1);
        for (int n = 0; n < 6; n++)
            send_word(1'b0);
        settle();

        write_targets('0, UNITY_Q15);
        for (int n = 0; n < 6; n++)
            send_word(n == 5);
        settle();

        // Random phases
        for (int ph = 0; ph < PHASES; ph++) begin
            write_targets(pick_target(), pick_target());
            case (ph % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct <= 0;
                end
                1: begin
                    src_idle_pct   = 70;
                    sink_stall_pct <= 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct <= 70;
                end
                default: begin
                    src_idle_pct   = 21;
                    sink_stall_pct <= 21;
                end
            endcase
            if (ph == 0)
                hold_arm <= 1'b1;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                send_word($urandom_range(7) == 0);
            settle();
        end

        if (book.pending_samples.size() != 0)
            book.report("requests left without a sample");
        if (book.errors == 0)
            $display("[filtered_noise_wind_synth] OK");
        else
            $display("[filtered_noise_wind_synth] ERROR");
        $finish;
    end

endmodule
